>>> rtl/cct_pkg.sv
// shared constants for the three-channel cascaded timer unit
// operation codes, register offsets, flag bits and reset values; no dependencies

package cct_pkg;

   // operation codes carried by an input beat
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // register offsets
   localparam logic [2:0] ADDR_CTRL   = 3'd0;  // control 1 or 3 on write, zero on read
   localparam logic [2:0] ADDR_STATUS = 3'd1;  // control 2 on write, status on read

   localparam int unsigned NUM_TIMERS = 3;
   localparam int unsigned CNT_W      = 16;

   typedef logic [CNT_W-1:0] count_type;
   typedef logic [7:0]       byte_type;

   // status and control bits
   localparam int unsigned STS_IRQ_BIT  = 7;
   localparam int unsigned CTL_IE_BIT   = 6;
   localparam int unsigned CTL_HOLD_BIT = 0;

   localparam count_type CNT_RESET = 16'hFFFF;

   // flag clearing after an armed status read also drops the irq bit
   localparam byte_type READ_CLR_MASK [NUM_TIMERS] = '{8'h7E, 8'h7D, 8'h7B};
   // a counter load clears the flag and leaves the irq bit alone
   localparam byte_type LOAD_CLR_MASK [NUM_TIMERS] = '{8'hFE, 8'hFD, 8'hFB};

endpackage

>>> rtl/three_channel_cascaded_timer_unit.sv
// top level of the three-channel cascaded timer unit
// depends on cct_pkg for operation codes, register offsets and masks

// Three-timer peripheral driven by a stream of beats. Each request beat is a tick,
// a byte read or a byte write to one of eight registers, and each produces exactly
// one response beat carrying the read byte (zero for ticks and writes) and the irq
// bit as it stands after that beat. On a tick timers 2 and 3 count down and reload
// from their 16-bit rates; timer 2 reaching zero toggles a square wave whose rising
// edges clock timer 1. Control 1 bit 0 holds all timers. Writes go through an msb
// latch and load rate and counter together; reading a counter's high byte latches
// its low byte. One beat is taken every clock: all state is updated in the cycle
// the request is accepted, and the response sits in a single output register, so
// a new request is accepted whenever that register is empty or being drained.
// The response appears in the cycle after the request is accepted.

module three_channel_cascaded_timer_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  logic [2:0]          req_address,
   input  logic [7:0]          req_write_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cct_pkg::byte_type   rsp_read_data,
   output logic                rsp_irq_pending
);
   import cct_pkg::*;

   // timer state
   count_type cnt_ff    [NUM_TIMERS];
   count_type cnt_in    [NUM_TIMERS];
   count_type reload_ff [NUM_TIMERS];
   count_type reload_in [NUM_TIMERS];
   byte_type  ctrl_ff   [NUM_TIMERS];
   byte_type  ctrl_in   [NUM_TIMERS];
   byte_type  status_ff, status_in;
   byte_type  hi_hold_ff, hi_hold_in;
   byte_type  lo_snap_ff, lo_snap_in;
   logic      wave_ff, wave_in;
   logic      clr_armed_ff, clr_armed_in;

   // response register
   logic      rsp_valid_ff, rsp_valid_in;
   byte_type  rsp_data_ff, rsp_data_in;
   logic      rsp_irq_ff, rsp_irq_in;

   logic      accept;
   logic [1:0] tmr_idx;

   // tick datapath
   count_type tick_cnt  [NUM_TIMERS];
   logic      tick_zero [NUM_TIMERS];
   logic      tick_wave;
   logic      tick_rise;
   byte_type  tick_status;
   logic      tick_raised;
   logic      tick_irq;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // counter index for offsets 2..7
   assign tmr_idx = req_address[2:1] - 2'd1;

   // reload when at zero, else decrement; zero flag on the result
   always_comb begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
         tick_cnt[t]  = (cnt_ff[t] == '0) ? reload_ff[t] : cnt_ff[t] - count_type'(1);
         tick_zero[t] = (tick_cnt[t] == '0);
      end
   end

   always_comb begin
      tick_wave   = wave_ff ^ tick_zero[1];
      // timer 1 only steps on a rising edge of the wave
      tick_rise   = tick_zero[1] && !wave_ff;
      tick_status = status_ff;
      if (tick_rise && tick_zero[0]) begin
         tick_status[0] = 1'b1;
      end
      if (tick_zero[1]) begin
         tick_status[1] = 1'b1;
      end
      if (tick_zero[2]) begin
         tick_status[2] = 1'b1;
      end
      tick_raised = tick_zero[1] || tick_zero[2];
      tick_irq    = 1'b0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
         tick_irq = tick_irq || (ctrl_ff[t][CTL_IE_BIT] && tick_status[t]);
      end
      if (tick_raised && tick_irq) begin
         tick_status[STS_IRQ_BIT] = 1'b1;
      end
   end

   // next state and response
   always_comb begin
      cnt_in       = cnt_ff;
      reload_in    = reload_ff;
      ctrl_in      = ctrl_ff;
      status_in    = status_ff;
      hi_hold_in   = hi_hold_ff;
      lo_snap_in   = lo_snap_ff;
      wave_in      = wave_ff;
      clr_armed_in = clr_armed_ff;
      rsp_data_in  = '0;

      unique case (req_operation)
         OP_TICK: begin
            if (!ctrl_ff[0][CTL_HOLD_BIT]) begin
               cnt_in[1] = tick_cnt[1];
               cnt_in[2] = tick_cnt[2];
               if (tick_rise) begin
                  cnt_in[0] = tick_cnt[0];
               end
               wave_in   = tick_wave;
               status_in = tick_status;
            end
         end
         OP_READ: begin
            priority if (req_address == ADDR_CTRL) begin
               rsp_data_in = '0;
            end else if (req_address == ADDR_STATUS) begin
               clr_armed_in = status_ff[STS_IRQ_BIT];
               rsp_data_in  = status_ff;
            end else if (req_address[0]) begin
               rsp_data_in = lo_snap_ff;
            end else begin
               if (clr_armed_ff) begin
                  status_in = status_ff & READ_CLR_MASK[tmr_idx];
               end
               lo_snap_in  = cnt_ff[tmr_idx][7:0];
               rsp_data_in = cnt_ff[tmr_idx][15:8];
            end
         end
         OP_WRITE: begin
            priority if (req_address == ADDR_CTRL) begin
               if (ctrl_ff[1][0]) begin
                  ctrl_in[0] = req_write_data;
                  if (req_write_data[CTL_HOLD_BIT]) begin
                     status_in = '0;
                  end
               end else begin
                  ctrl_in[2] = req_write_data;
               end
            end else if (req_address == ADDR_STATUS) begin
               ctrl_in[1] = req_write_data;
            end else if (!req_address[0]) begin
               hi_hold_in = req_write_data;
            end else begin
               status_in          = status_ff & LOAD_CLR_MASK[tmr_idx];
               reload_in[tmr_idx] = {hi_hold_ff, req_write_data};
               cnt_in[tmr_idx]    = {hi_hold_ff, req_write_data};
            end
         end
         default: begin
            // unused operation code changes nothing
         end
      endcase

      rsp_irq_in = status_in[STS_IRQ_BIT];

      // response register loads on accept and empties on drain
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_TIMERS; t++) begin
            cnt_ff[t]    <= CNT_RESET;
            reload_ff[t] <= CNT_RESET;
            ctrl_ff[t]   <= '0;
         end
         status_ff    <= '0;
         hi_hold_ff   <= '0;
         lo_snap_ff   <= '0;
         wave_ff      <= 1'b0;
         clr_armed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            cnt_ff       <= cnt_in;
            reload_ff    <= reload_in;
            ctrl_ff      <= ctrl_in;
            status_ff    <= status_in;
            hi_hold_ff   <= hi_hold_in;
            lo_snap_ff   <= lo_snap_in;
            wave_ff      <= wave_in;
            clr_armed_ff <= clr_armed_in;
         end
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_irq_ff  <= rsp_irq_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_irq_pending = rsp_irq_ff;

endmodule
